>>> rtl/filament_motion_runout_detector_unit_macros.svh
// Assertion macros for the filament motion runout detector.
// Expects clk and arst_n in the scope of every use.
`ifndef FILAMENT_MOTION_RUNOUT_DETECTOR_UNIT_MACROS_SVH
`define FILAMENT_MOTION_RUNOUT_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset only
`define FMRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only
`define FMRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fmrd_pkg.sv
// Shared types and constants of the filament motion runout detector.
// No dependencies; used by the channel interfaces and the top level.
package fmrd_pkg;

	localparam int NUM_EXTRUDERS = 2;
	localparam int CH_W          = 1;
	localparam int ADC_BITS      = 12;
	localparam int CNT_W         = 24;
	localparam int WIN_W         = 23;
	localparam int THR_W         = 12;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 23;

	// item operations
	localparam logic OP_STEP   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_WINDOW_0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_WINDOW_1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STALL_THRESHOLD = 3'd4;

	// register reset values
	localparam logic [WIN_W-1:0] WINDOW_RESET    = 23'd4096;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd100;

	// step counter saturation limits
	localparam logic signed [CNT_W-1:0] CNT_MAX = 24'sh7FFFFF;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 24'sh800000;

	typedef struct packed {
		logic                operation;
		logic [CH_W-1:0]     extruder;
		logic                forward;
		logic [ADC_BITS-1:0] adc_sample;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            window_closed;
		logic            stall_seen;
		logic            runout;
	} result_t;

endpackage

>>> rtl/fmrd_intf.sv
// Valid/ready channel interfaces of the filament motion runout detector.
// Depends on fmrd_pkg for the payload types.
interface fmrd_item_if import fmrd_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fmrd_result_if import fmrd_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fmrd_cfg_if import fmrd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/filament_motion_runout_detector_unit.sv
// Channel    | Dir  | Payload                                        | Accepted when
// item       | sink | operation, extruder, forward, adc_sample       | valid && ready
// result     | src  | channel, window_closed, stall_seen, runout     | valid && ready
// cfg        | sink | index, data                                    | valid && ready
//
// One item per cycle while item.ready is high: the per-channel state is updated at the
// edge that accepts the item, and its result lands at that same edge in the output
// register, or in a skid register while the output register still holds a result, so
// item.ready drops only while both output slots are full.
// Asynchronous active-low reset clears all channel state, registers to defaults.
// cfg.ready is always high.
//
// Top level of the filament motion runout detector.
// Depends on fmrd_pkg, fmrd_intf.sv and the assertion macro header.
`include "filament_motion_runout_detector_unit_macros.svh"

module filament_motion_runout_detector_unit
	import fmrd_pkg::*;
#(
	parameter int HISTORY_LEN = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	fmrd_item_if.sink    item,
	fmrd_result_if.source result,
	fmrd_cfg_if.sink     cfg
);

	// configuration registers
	logic [WIN_W-1:0] window_q [NUM_EXTRUDERS];
	logic             reverse_q [NUM_EXTRUDERS];
	logic [THR_W-1:0] threshold_q;

	// per-channel state
	logic signed [CNT_W-1:0]    count_q [NUM_EXTRUDERS];
	logic [ADC_BITS-1:0]        ref_q [NUM_EXTRUDERS];
	logic [HISTORY_LEN-1:0]     hist_q [NUM_EXTRUDERS];
	logic                       runout_q [NUM_EXTRUDERS];

	// output register and skid
	result_t result_q, skid_q;
	logic    result_valid_q, skid_valid_q;

	logic push, pop;

	// selected channel values and their next state
	logic [CH_W-1:0]            ch;
	logic signed [CNT_W-1:0]    cnt, cnt_nxt;
	logic [ADC_BITS-1:0]        ref_cur, ref_nxt;
	logic [HISTORY_LEN-1:0]     hist_nxt;
	logic [HISTORY_LEN:0]       hist_ext;
	logic                       runout_nxt;
	logic signed [CNT_W:0]      cnt_x, win_x, neg_win_x;
	logic signed [ADC_BITS:0]   diff, diff_adj, thr_x;
	logic                       reached, stall, closed;
	result_t                    res_new;

	assign push         = item.valid && item.ready;
	assign pop          = result_valid_q && result.ready;
	assign item.ready   = !skid_valid_q;
	assign cfg.ready    = 1'b1;
	assign result.valid = result_valid_q;
	assign result.data  = result_q;

	// work out the effect of one request on its channel
	always_comb begin
		ch        = item.data.extruder;
		cnt       = count_q[ch];
		ref_cur   = ref_q[ch];
		cnt_x     = {cnt[CNT_W-1], cnt};
		win_x     = $signed({2'b00, window_q[ch]});
		neg_win_x = -win_x;
		reached   = (cnt_x >= win_x) || (cnt_x <= neg_win_x);
		diff      = $signed({1'b0, item.data.adc_sample}) - $signed({1'b0, ref_cur});
		diff_adj  = (reverse_q[ch] ^ cnt[CNT_W-1]) ? -diff : diff;
		thr_x     = $signed({1'b0, threshold_q});
		stall     = 1'b0;
		closed    = 1'b0;
		cnt_nxt   = cnt;
		ref_nxt   = ref_cur;
		hist_nxt  = hist_q[ch];
		runout_nxt = runout_q[ch];
		hist_ext  = '0;
		if (item.data.operation == OP_STEP) begin
			if (item.data.forward) begin
				if (cnt != CNT_MAX) cnt_nxt = cnt + 24'sd1;
			end else begin
				if (cnt != CNT_MIN) cnt_nxt = cnt - 24'sd1;
			end
		end else if (ref_cur == '0) begin
			cnt_nxt = '0;
			ref_nxt = item.data.adc_sample;
		end else if (reached) begin
			stall    = (diff_adj >= 0) && (diff_adj < thr_x);
			hist_ext = {hist_q[ch], stall};
			hist_nxt = hist_ext[HISTORY_LEN-1:0];
			if (&hist_nxt) runout_nxt = 1'b1;
			else if (hist_nxt == '0) runout_nxt = 1'b0;
			closed  = 1'b1;
			cnt_nxt = '0;
			ref_nxt = item.data.adc_sample;
		end
		res_new.channel       = ch;
		res_new.window_closed = closed;
		res_new.stall_seen    = stall;
		res_new.runout        = runout_nxt;
	end

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q[0]  <= WINDOW_RESET;
			window_q[1]  <= WINDOW_RESET;
			reverse_q[0] <= 1'b0;
			reverse_q[1] <= 1'b0;
			threshold_q  <= THRESHOLD_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STEP_WINDOW_0:   window_q[0]  <= cfg.data[WIN_W-1:0];
				REG_STEP_WINDOW_1:   window_q[1]  <= cfg.data[WIN_W-1:0];
				REG_REVERSE_0:       reverse_q[0] <= cfg.data[0];
				REG_REVERSE_1:       reverse_q[1] <= cfg.data[0];
				REG_STALL_THRESHOLD: threshold_q  <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// update channel state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_EXTRUDERS; i++) begin
				count_q[i]  <= '0;
				ref_q[i]    <= '0;
				hist_q[i]   <= '0;
				runout_q[i] <= 1'b0;
			end
		end else if (push) begin
			count_q[ch]  <= cnt_nxt;
			ref_q[ch]    <= ref_nxt;
			hist_q[ch]   <= hist_nxt;
			runout_q[ch] <= runout_nxt;
		end
	end

	// output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!push) begin
					result_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (result_valid_q) skid_valid_q <= 1'b1;
				else result_valid_q <= 1'b1;
			end
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			result_q <= skid_q;
		end else if (push && (!result_valid_q || pop)) begin
			result_q <= res_new;
		end
		if (push && result_valid_q && !pop) begin
			skid_q <= res_new;
		end
	end

	`FMRD_ASSERT_NOW(a_skid_behind_out, skid_valid_q, result_valid_q, "skid full with output empty")
	`FMRD_ASSERT_NEXT(a_stalled_push_skids, push && result_valid_q && !result.ready, skid_valid_q, "stalled result not held in skid")
	`FMRD_ASSERT_NOW(a_step_no_window, push && item.data.operation == OP_STEP, !res_new.window_closed, "step request closed a window")
	`FMRD_ASSERT_NOW(a_stall_needs_window, res_new.stall_seen, res_new.window_closed, "stall without closed window")

endmodule

>>> tb/sv/filament_motion_runout_detector_unit_tb.sv
// Testbench for the filament motion runout detector: a table of directed requests, then
// random motion bursts, each result checked against a cycle-free model of the channels.
// Depends on fmrd_pkg, the channel interfaces in fmrd_intf.sv and the RTL top level.
module filament_motion_runout_detector_unit_tb import fmrd_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_LEN      = 8;
	localparam int GAP_MAX       = 18;
	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 650;
	localparam int PHASE_ITEMS   = 70;
	localparam int SETTLE_CYCLES = 3;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;
	localparam int ADC_TOP       = (1 << ADC_BITS) - 1;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		item_t                 req;
		logic                  typed;
		result_t               want;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fmrd_item_if   item_req ();
	fmrd_result_if result_rsp ();
	fmrd_cfg_if    cfg_wr ();

	filament_motion_runout_detector_unit #(
		.HISTORY_LEN(HIST_LEN)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_req),
		.result(result_rsp),
		.cfg   (cfg_wr)
	);

	// model state per channel
	logic signed [CNT_W-1:0]    step_tally  [NUM_EXTRUDERS];
	logic [ADC_BITS-1:0]        ref_level   [NUM_EXTRUDERS];
	logic [HIST_LEN-1:0]        stall_hist  [NUM_EXTRUDERS];
	logic                       runout_state[NUM_EXTRUDERS];
	// model copy of the registers
	logic [WIN_W-1:0]           window_len  [NUM_EXTRUDERS];
	logic                       reverse_dir [NUM_EXTRUDERS];
	logic [THR_W-1:0]           stall_limit;

	result_t expected_q[$];
	int      mismatches = 0;
	int      cycles     = 0;
	int      items_sent = 0;
	bit      send_calm  = 1'b0;
	bit      take_calm  = 1'b0;
	int      stall_pct [NUM_EXTRUDERS];
	int      mode_left [NUM_EXTRUDERS];

	always begin
		#10ns clk = 1'b1;
		#10ns clk = 1'b0;
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Advance one channel by one request and return the status it reports
	function automatic result_t motion_check(input item_t it);
		result_t             r;
		int                  ch, cnt, win, diff, lvl, now, lim;
		logic [HIST_LEN-1:0] h;
		r = '0;
		r.channel = it.extruder;
		ch = int'(it.extruder);
		if (ch >= NUM_EXTRUDERS)
			return r;
		if (it.operation == OP_STEP) begin
			if (it.forward) begin
				if (step_tally[ch] != CNT_MAX)
					step_tally[ch] = step_tally[ch] + 24'sd1;
			end else if (step_tally[ch] != CNT_MIN) begin
				step_tally[ch] = step_tally[ch] - 24'sd1;
			end
		end else if (ref_level[ch] == '0) begin
			// no reference held: capture it and restart the count
			step_tally[ch] = '0;
			ref_level[ch] = it.adc_sample;
		end else begin
			cnt = int'(step_tally[ch]);
			win = int'(window_len[ch]);
			if (cnt >= win || cnt <= -win) begin
				now = int'(it.adc_sample);
				lvl = int'(ref_level[ch]);
				lim = int'(stall_limit);
				diff = now - lvl;
				if (reverse_dir[ch])
					diff = -diff;
				if (cnt < 0)
					diff = -diff;
				h = stall_hist[ch] << 1;
				if (diff >= 0 && diff < lim) begin
					h[0] = 1'b1;
					r.stall_seen = 1'b1;
				end
				stall_hist[ch] = h;
				if (h == '1 || h == '0)
					runout_state[ch] = h[0];
				r.window_closed = 1'b1;
				step_tally[ch] = '0;
				ref_level[ch] = it.adc_sample;
			end
		end
		r.runout = runout_state[ch];
		return r;
	endfunction

	function automatic row_t checked_row(input logic op, input logic ch, input logic fwd,
			input logic [ADC_BITS-1:0] adc);
		row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.req.operation = op;
		r.req.extruder = ch;
		r.req.forward = fwd;
		r.req.adc_sample = adc;
		return r;
	endfunction

	function automatic row_t fixed_row(input logic op, input logic ch, input logic fwd,
			input logic [ADC_BITS-1:0] adc, input logic closed, input logic stall,
			input logic run);
		row_t r;
		r = checked_row(op, ch, fwd, adc);
		r.typed = 1'b1;
		r.want.channel = ch;
		r.want.window_closed = closed;
		r.want.stall_seen = stall;
		r.want.runout = run;
		return r;
	endfunction

	function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	// Offer one request after a random gap, hold it until accepted, queue its result
	task automatic send_item(input item_t it, input logic typed, input result_t want);
		int      gap;
		result_t pred;
		gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			item_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_req.valid <= 1'b1;
		item_req.data <= it;
		do @(posedge clk); while (!item_req.ready);
		pred = motion_check(it);
		expected_q.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// Drop the request line and wait until every result is back
	task automatic settle_idle();
		item_req.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller drops valid after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_wr.valid <= 1'b1;
		cfg_wr.index <= idx;
		cfg_wr.data <= val;
		do @(posedge clk); while (!cfg_wr.ready);
		case (idx)
			REG_STEP_WINDOW_0: window_len[0] = val[WIN_W-1:0];
			REG_STEP_WINDOW_1: window_len[1] = val[WIN_W-1:0];
			REG_REVERSE_0: reverse_dir[0] = val[0];
			REG_REVERSE_1: reverse_dir[1] = val[0];
			REG_STALL_THRESHOLD: stall_limit = val[THR_W-1:0];
			default: ;
		endcase
	endtask

	// Window's steps plus up to two (1 to 16 if window > 16), then a sample aimed inside or outside the stall band
	task automatic motion_burst(input int ch);
		item_t it;
		int    n, w, d, s, a, lim, lvl;
		bit    dir, want_stall;
		// keep a channel stall-heavy or move-heavy for a while so the history fills
		if (mode_left[ch] == 0) begin
			case ($urandom_range(0, 2))
				0: stall_pct[ch] = 95;
				1: stall_pct[ch] = 10;
				default: stall_pct[ch] = 50;
			endcase
			mode_left[ch] = $urandom_range(4, 14);
		end
		mode_left[ch]--;
		w = int'(window_len[ch]);
		lim = int'(stall_limit);
		n = (w > 16) ? $urandom_range(1, 16) : w + $urandom_range(0, 2);
		dir = 1'($urandom_range(0, 1));
		it.extruder = CH_W'(ch);
		repeat (n) begin
			it.operation = OP_STEP;
			it.forward = ($urandom_range(0, 7) == 0) ? ~dir : dir;
			it.adc_sample = ADC_BITS'($urandom_range(0, ADC_TOP));
			send_item(it, 1'b0, '0);
		end
		lvl = int'(ref_level[ch]);
		want_stall = $urandom_range(0, 99) < stall_pct[ch];
		if (want_stall && lim > 0)
			d = $urandom_range(0, lim - 1);
		else if ($urandom_range(0, 3) == 0)
			d = -int'($urandom_range(1, 400));
		else
			d = $urandom_range(lim, ADC_TOP);
		s = (reverse_dir[ch] ^ (step_tally[ch] < 0)) ? -1 : 1;
		a = lvl + s * d;
		if (lvl == 0 || a < 0 || a > ADC_TOP)
			a = $urandom_range(0, ADC_TOP);
		it.operation = OP_SAMPLE;
		it.forward = 1'($urandom_range(0, 1));
		it.adc_sample = ADC_BITS'(a);
		send_item(it, 1'b0, '0);
	endtask

	// Stall the result side at random and check each result against the oldest expectation
	initial begin
		int      n;
		result_t got, want;
		wait (arst_n === 1'b1);
		forever begin
			n = take_calm ? 0 : $urandom_range(0, GAP_MAX);
			if (n > 0) begin
				result_rsp.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_rsp.ready <= 1'b1;
			do @(posedge clk); while (!(result_rsp.valid && result_rsp.ready));
			got = result_rsp.data;
			if (expected_q.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected result ch=%0d closed=%0b stall=%0b runout=%0b",
						got.channel, got.window_closed, got.stall_seen, got.runout);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (got.channel !== want.channel ||
						got.window_closed !== want.window_closed ||
						got.stall_seen !== want.stall_seen || got.runout !== want.runout) begin
					if (mismatches < REPORT_MAX) begin
						$display("mismatch: expected ch=%0d closed=%0b stall=%0b runout=%0b",
							want.channel, want.window_closed, want.stall_seen, want.runout);
						$display("          got      ch=%0d closed=%0b stall=%0b runout=%0b",
							got.channel, got.window_closed, got.stall_seen, got.runout);
					end
					mismatches++;
				end
			end
		end
	end

	// Reset, directed table, random phases, verdict
	initial begin
		row_t  rows [DIRECTED_ROWS];
		row_t  tail;
		item_t it;
		int    base, phase_end, p, w0, w1, rv0, rv1, thr;
		item_req.valid <= 1'b0;
		item_req.data <= '0;
		result_rsp.ready <= 1'b0;
		cfg_wr.valid <= 1'b0;
		cfg_wr.index <= '0;
		cfg_wr.data <= '0;
		for (int i = 0; i < NUM_EXTRUDERS; i++) begin
			step_tally[i] = '0;
			ref_level[i] = '0;
			stall_hist[i] = '0;
			runout_state[i] = 1'b0;
			window_len[i] = WINDOW_RESET;
			reverse_dir[i] = 1'b0;
			stall_pct[i] = 50;
			mode_left[i] = 0;
		end
		stall_limit = THRESHOLD_RESET;

		rows = '{
			// defaults after reset: nothing can close yet
			fixed_row(OP_STEP,   1'b0, 1'b1, 12'h000, 1'b0, 1'b0, 1'b0),
			fixed_row(OP_STEP,   1'b1, 1'b0, 12'hFFF, 1'b0, 1'b0, 1'b0),
			// zero reading leaves the reference empty, so the next sample captures
			fixed_row(OP_SAMPLE, 1'b0, 1'b0, 12'h000, 1'b0, 1'b0, 1'b0),
			fixed_row(OP_SAMPLE, 1'b0, 1'b1, 12'hFFF, 1'b0, 1'b0, 1'b0),
			fixed_row(OP_SAMPLE, 1'b1, 1'b0, 12'h800, 1'b0, 1'b0, 1'b0),
			// reference held but window not reached
			fixed_row(OP_SAMPLE, 1'b0, 1'b0, 12'h123, 1'b0, 1'b0, 1'b0),
			reg_row(REG_STEP_WINDOW_0, 23'd1),
			checked_row(OP_STEP,   1'b0, 1'b1, 12'h000),
			checked_row(OP_SAMPLE, 1'b0, 1'b0, 12'hFFF),
			// reverse travel flips the change
			checked_row(OP_STEP,   1'b0, 1'b0, 12'h000),
			checked_row(OP_SAMPLE, 1'b0, 1'b0, 12'hF00),
			reg_row(REG_REVERSE_0, 23'd1),
			checked_row(OP_STEP,   1'b0, 1'b1, 12'h000),
			checked_row(OP_SAMPLE, 1'b0, 1'b0, 12'hF50),
			// threshold of zero never flags a stall
			reg_row(REG_STALL_THRESHOLD, 23'd0),
			checked_row(OP_STEP,   1'b0, 1'b1, 12'h000),
			checked_row(OP_SAMPLE, 1'b0, 1'b0, 12'hF50),
			// widest threshold; closing on a zero reading empties the reference
			reg_row(REG_STALL_THRESHOLD, 23'd4095),
			checked_row(OP_STEP,   1'b0, 1'b1, 12'h000),
			checked_row(OP_SAMPLE, 1'b0, 1'b0, 12'h000),
			// window of zero: every sample with a reference closes
			reg_row(REG_STEP_WINDOW_0, 23'd0),
			checked_row(OP_SAMPLE, 1'b0, 1'b0, 12'h005),
			checked_row(OP_SAMPLE, 1'b0, 1'b1, 12'h006),
			reg_row(REG_STEP_WINDOW_1, 23'h7FFFFF),
			reg_row(REG_REVERSE_1, 23'd1)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG) begin
				settle_idle();
				write_reg(rows[i].idx, rows[i].val);
				cfg_wr.valid <= 1'b0;
			end else begin
				send_item(rows[i].req, rows[i].typed, rows[i].want);
			end
		end
		// widest window on extruder 1 never closes
		tail = fixed_row(OP_STEP, 1'b1, 1'b1, 12'hFFF, 1'b0, 1'b0, 1'b0);
		send_item(tail.req, tail.typed, tail.want);
		tail = fixed_row(OP_SAMPLE, 1'b1, 1'b1, 12'h7FF, 1'b0, 1'b0, 1'b0);
		send_item(tail.req, tail.typed, tail.want);

		// random phases, each with fresh register settings written while idle
		base = items_sent;
		p = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			settle_idle();
			case (p)
				0: begin
					w0 = 1;
					w1 = 1;
					thr = 4095;
				end
				1: begin
					w0 = $urandom_range(1, 8);
					w1 = $urandom_range(1, 8);
					thr = 0;
				end
				2: begin
					w0 = 8388607;
					w1 = $urandom_range(1, 6);
					thr = $urandom_range(50, 400);
				end
				default: begin
					w0 = $urandom_range(1, 12);
					w1 = $urandom_range(1, 12);
					thr = $urandom_range(1, 800);
					if ($urandom_range(0, 5) == 0)
						thr = $urandom_range(0, 4095);
				end
			endcase
			rv0 = $urandom_range(0, 1);
			rv1 = $urandom_range(0, 1);
			write_reg(REG_STEP_WINDOW_0, CFG_DATA_W'(w0));
			write_reg(REG_STEP_WINDOW_1, CFG_DATA_W'(w1));
			write_reg(REG_REVERSE_0, CFG_DATA_W'(rv0));
			write_reg(REG_REVERSE_1, CFG_DATA_W'(rv1));
			write_reg(REG_STALL_THRESHOLD, CFG_DATA_W'(thr));
			cfg_wr.valid <= 1'b0;
			send_calm = ($urandom_range(0, 3) == 0);
			take_calm = ($urandom_range(0, 3) == 0);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 3) != 0) begin
					motion_burst($urandom_range(0, NUM_EXTRUDERS - 1));
				end else begin
					// noise: any field, any channel
					it.operation = 1'($urandom_range(0, 1));
					it.extruder = CH_W'($urandom_range(0, NUM_EXTRUDERS - 1));
					it.forward = 1'($urandom_range(0, 1));
					it.adc_sample = ADC_BITS'($urandom_range(0, ADC_TOP));
					send_item(it, 1'b0, '0);
				end
			end
			p++;
		end

		settle_idle();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/fmrd_pkg.sv
rtl/fmrd_intf.sv
rtl/filament_motion_runout_detector_unit.sv
tb/sv/filament_motion_runout_detector_unit_tb.sv
